FILE: src/i2c_memory_master_core_assert.svh
// Assertion macros used by the checker of the I2C memory master.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef I2C_MEMORY_MASTER_CORE_ASSERT_SVH
`define I2C_MEMORY_MASTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/i2cmm_pkg.sv
// ----------------------------------------------------------------------------
// I2C memory master package
// Command codes, reset values and the word types of the two channels.
// ----------------------------------------------------------------------------
package i2cmm_pkg;

  // Command codes carried in the func field.
  localparam logic [1:0] FUNC_TICK        = 2'd0;
  localparam logic [1:0] FUNC_BEGIN_READ  = 2'd1;
  localparam logic [1:0] FUNC_BEGIN_WRITE = 2'd2;
  localparam logic [1:0] FUNC_SUPPLY      = 2'd3;

  // Bus address of the memory after reset.
  localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

  // Direction bit appended to the device address.
  localparam logic DIR_WRITE = 1'b0;
  localparam logic DIR_READ  = 1'b1;

  // One command word.
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] mem_addr;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_in;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       byte_request;
    logic       busy_res;
    logic       done_res;
    logic       success;
  } out_item_t;

endpackage

FILE: src/i2cmm_if.sv
// ----------------------------------------------------------------------------
// I2C memory master channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface i2cmm_in_if;
  logic               valid;
  logic               ready;
  i2cmm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cmm_out_if;
  logic                valid;
  logic                ready;
  i2cmm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/i2c_memory_master_core.sv
// ----------------------------------------------------------------------------
// I2C memory master core
// Bus master for a memory with two-byte addressing, one bus phase per tick.
// ----------------------------------------------------------------------------
// The result word of an accepted command is registered in the output or skid word.
// Throughput: one command word per cycle while the skid word is empty.
// A two-word output buffer keeps the input open while one result waits.
// Reset (rst_n low, synchronous) idles the bus with both lines released and
// restores the device address to 80.
module i2c_memory_master_core (
  input  logic        clk,
  input  logic        rst_n,
  i2cmm_in_if.sink    in_ch,
  i2cmm_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_RS_A, PH_ST_B, PH_ST_C, PH_ST_D, PH_TX_LOW, PH_TX_HIGH,
    PH_ACK_LOW, PH_ACK_HIGH, PH_WAIT_BYTE, PH_RX_LOW, PH_RX_HIGH,
    PH_MACK_LOW, PH_MACK_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  typedef enum logic [2:0] {
    SG_DEVW, SG_ADRH, SG_ADRL, SG_DEVR, SG_DATA
  } stage_t;

  phase_t      phase_r, phase_nxt;
  stage_t      stage_r, stage_nxt;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] address_r, address_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  pending_byte_r, pending_byte_nxt;
  logic        pending_valid_r, pending_valid_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        failed_r, failed_nxt;
  logic [6:0]  dev_addr_r;

  i2cmm_pkg::out_item_t res;
  i2cmm_pkg::in_item_t  cmd;
  i2cmm_pkg::out_item_t out_data_r, skid_data_r;
  logic                 out_valid_r, skid_valid_r;
  logic                 accept, pop;
  logic [15:0]          bytes_dec;

  assign cmd          = in_ch.data;
  assign in_ch.ready  = !skid_valid_r;
  assign accept       = in_ch.valid && !skid_valid_r;
  assign pop          = out_valid_r && out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign bytes_dec    = bytes_left_r - 16'd1;

  // Next state of the bus sequencer for the accepted command word.
  always_comb begin
    phase_nxt         = phase_r;
    stage_nxt         = stage_r;
    bit_index_nxt     = bit_index_r;
    shift_nxt         = shift_r;
    bytes_left_nxt    = bytes_left_r;
    address_nxt       = address_r;
    is_read_nxt       = is_read_r;
    pending_byte_nxt  = pending_byte_r;
    pending_valid_nxt = pending_valid_r;
    scl_nxt           = scl_r;
    sda_nxt           = sda_r;
    failed_nxt        = failed_r;
    res               = '0;

    if (accept) begin
      case (cmd.func)
        i2cmm_pkg::FUNC_BEGIN_READ, i2cmm_pkg::FUNC_BEGIN_WRITE: begin
          if (phase_r == PH_IDLE) begin
            address_nxt       = cmd.mem_addr;
            bytes_left_nxt    = cmd.byte_count;
            is_read_nxt       = (cmd.func == i2cmm_pkg::FUNC_BEGIN_READ);
            pending_valid_nxt = 1'b0;
            failed_nxt        = 1'b0;
            stage_nxt         = SG_DEVW;
            bit_index_nxt     = 3'd0;
            phase_nxt         = PH_ST_B;
          end
        end
        i2cmm_pkg::FUNC_SUPPLY: begin
          if (phase_r != PH_IDLE) begin
            pending_byte_nxt  = cmd.write_byte;
            pending_valid_nxt = 1'b1;
          end
        end
        default: begin
          case (phase_r)
            PH_IDLE: begin
              phase_nxt = PH_IDLE;
            end
            PH_RS_A: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
              phase_nxt = PH_ST_B;
            end
            PH_ST_B: begin
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
              phase_nxt = PH_ST_C;
            end
            PH_ST_C: begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_ST_D;
            end
            PH_ST_D: begin
              scl_nxt       = 1'b0;
              shift_nxt     = {dev_addr_r, (stage_r == SG_DEVR) ? i2cmm_pkg::DIR_READ
                                                                : i2cmm_pkg::DIR_WRITE};
              bit_index_nxt = 3'd0;
              phase_nxt     = PH_TX_LOW;
            end
            PH_TX_LOW: begin
              scl_nxt   = 1'b0;
              sda_nxt   = shift_r[7];
              phase_nxt = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], 1'b0};
              if (bit_index_r == 3'd7) begin
                bit_index_nxt = 3'd0;
                phase_nxt     = PH_ACK_LOW;
              end else begin
                bit_index_nxt = bit_index_r + 3'd1;
                phase_nxt     = PH_TX_LOW;
              end
            end
            PH_ACK_LOW: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
              phase_nxt = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
              scl_nxt = 1'b1;
              if (cmd.sda_in) begin
                // The target did not acknowledge: stop and report failure.
                failed_nxt = 1'b1;
                phase_nxt  = PH_STOP_A;
              end else begin
                // Pick the next byte according to where the header stands.
                case (stage_r)
                  SG_DEVW: begin
                    shift_nxt = address_r[15:8];
                    stage_nxt = SG_ADRH;
                    phase_nxt = PH_TX_LOW;
                  end
                  SG_ADRH: begin
                    shift_nxt = address_r[7:0];
                    stage_nxt = SG_ADRL;
                    phase_nxt = PH_TX_LOW;
                  end
                  SG_ADRL: begin
                    if (is_read_r) begin
                      stage_nxt = SG_DEVR;
                      phase_nxt = PH_RS_A;
                    end else if (bytes_left_r == 16'd0) begin
                      failed_nxt = 1'b0;
                      phase_nxt  = PH_STOP_A;
                    end else begin
                      stage_nxt = SG_DATA;
                      phase_nxt = PH_WAIT_BYTE;
                    end
                  end
                  SG_DEVR: begin
                    if (bytes_left_r == 16'd0) begin
                      failed_nxt = 1'b0;
                      phase_nxt  = PH_STOP_A;
                    end else begin
                      shift_nxt     = 8'd0;
                      bit_index_nxt = 3'd0;
                      phase_nxt     = PH_RX_LOW;
                    end
                  end
                  SG_DATA: begin
                    bytes_left_nxt = bytes_dec;
                    if (bytes_dec == 16'd0) begin
                      failed_nxt = 1'b0;
                      phase_nxt  = PH_STOP_A;
                    end else begin
                      phase_nxt = PH_WAIT_BYTE;
                    end
                  end
                  default: begin
                    phase_nxt = PH_IDLE;
                  end
                endcase
              end
            end
            PH_WAIT_BYTE: begin
              // Hold SCL low until a data byte is on hand.
              scl_nxt = 1'b0;
              if (pending_valid_r) begin
                shift_nxt         = pending_byte_r;
                pending_valid_nxt = 1'b0;
                bit_index_nxt     = 3'd0;
                phase_nxt         = PH_TX_LOW;
              end
            end
            PH_RX_LOW: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
              phase_nxt = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], cmd.sda_in};
              if (bit_index_r == 3'd7) begin
                bit_index_nxt = 3'd0;
                phase_nxt     = PH_MACK_LOW;
              end else begin
                bit_index_nxt = bit_index_r + 3'd1;
                phase_nxt     = PH_RX_LOW;
              end
            end
            PH_MACK_LOW: begin
              // Present the byte and answer ACK, or NACK on the last one.
              scl_nxt        = 1'b0;
              sda_nxt        = !(bytes_left_r > 16'd1);
              res.read_valid = 1'b1;
              res.read_byte  = shift_r;
              res.read_last  = (bytes_left_r == 16'd1);
              phase_nxt      = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
              scl_nxt        = 1'b1;
              bytes_left_nxt = bytes_dec;
              if (bytes_dec == 16'd0) begin
                failed_nxt = 1'b0;
                phase_nxt  = PH_STOP_A;
              end else begin
                shift_nxt     = 8'd0;
                bit_index_nxt = 3'd0;
                phase_nxt     = PH_RX_LOW;
              end
            end
            PH_STOP_A: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              phase_nxt = PH_STOP_B;
            end
            PH_STOP_B: begin
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b0;
              phase_nxt = PH_STOP_C;
            end
            PH_STOP_C: begin
              scl_nxt      = 1'b1;
              sda_nxt      = 1'b1;
              res.done_res = 1'b1;
              res.success  = !failed_r;
              phase_nxt    = PH_IDLE;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      endcase
    end

    // Line levels and status as they stand after this word.
    res.scl_out      = scl_nxt;
    res.sda_out      = sda_nxt;
    res.byte_request = (phase_nxt == PH_WAIT_BYTE) && !pending_valid_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
  end

  // Sequencer state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      stage_r         <= SG_DEVW;
      bit_index_r     <= 3'd0;
      shift_r         <= 8'd0;
      bytes_left_r    <= 16'd0;
      address_r       <= 16'd0;
      is_read_r       <= 1'b0;
      pending_valid_r <= 1'b0;
      scl_r           <= 1'b1;
      sda_r           <= 1'b1;
      failed_r        <= 1'b0;
      dev_addr_r      <= i2cmm_pkg::DEV_ADDR_RESET;
    end else begin
      phase_r         <= phase_nxt;
      stage_r         <= stage_nxt;
      bit_index_r     <= bit_index_nxt;
      shift_r         <= shift_nxt;
      bytes_left_r    <= bytes_left_nxt;
      address_r       <= address_nxt;
      is_read_r       <= is_read_nxt;
      pending_valid_r <= pending_valid_nxt;
      scl_r           <= scl_nxt;
      sda_r           <= sda_nxt;
      failed_r        <= failed_nxt;
      if (cfg_we) begin
        dev_addr_r <= cfg_data;
      end
    end
  end

  // The held write byte only counts while its valid flag is set.
  always_ff @(posedge clk) begin
    pending_byte_r <= pending_byte_nxt;
  end

  // Output register with a skid word behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: src/i2cmm_checker.sv
// ----------------------------------------------------------------------------
// I2C memory master checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "i2c_memory_master_core_assert.svh"

module i2cmm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cmm_pkg::out_item_t out_data
);

  // A finished transaction is never reported as still open.
  `I2CMM_ASSERT_NOW(a_done_not_busy, clk, rst_n, out_valid && out_data.done_res, !out_data.busy_res, "done reported while busy")

  // Success is only reported together with the end of a transaction.
  `I2CMM_ASSERT_NOW(a_success_with_done, clk, rst_n, out_valid && out_data.success, out_data.done_res, "success without done")

  // A received byte is presented inside a read, with SCL held low and a zero byte otherwise.
  `I2CMM_ASSERT_NOW(a_read_in_txn, clk, rst_n, out_valid && out_data.read_valid, out_data.busy_res && !out_data.scl_out, "read byte outside an open transaction")

  // A stalled result word stays offered.
  `I2CMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind i2c_memory_master_core i2cmm_checker u_i2cmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
